// File: design/rgb_to_rgbw_pixel_converter_core_defines.svh
// assertion macros for the rgbw pixel converter
// used by rgb_to_rgbw_pixel_converter_core.sv; no other dependencies
`ifndef RGB_TO_RGBW_PIXEL_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_RGBW_PIXEL_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RGBW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbw check failed: same cycle");

// next-cycle implication, checked outside reset
`define RGBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbw check failed: next cycle");

`endif

// File: design/rgbw_pkg.sv
// shared types and codes for the rgbw pixel converter
// no dependencies
`default_nettype none

package rgbw_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CONVERT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_SLOT   = 3'd4;

    typedef enum logic [1:0] {
        MODE_EXACT       = 2'd0,
        MODE_MAX_BRIGHT  = 2'd1,
        MODE_NULL_WHITE  = 2'd2,
        MODE_WHITE_BOOST = 2'd3
    } convert_mode_t;

    typedef struct packed {
        convert_mode_t convert_mode;
        logic [7:0]    red_gain;
        logic [7:0]    green_gain;
        logic [7:0]    blue_gain;
        logic [1:0]    white_slot;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] slot0;
        logic [7:0] slot1;
        logic [7:0] slot2;
        logic [7:0] slot3;
    } rgbw_t;

endpackage

`default_nettype wire

// File: design/rgbw_cfg.sv
// configuration register file: mode, three gains, white slot
// depends on rgbw_pkg
`default_nettype none

module rgbw_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rgbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbw_pkg::CFG_DATA_W-1:0] cfg_data,
    output rgbw_pkg::cfg_t                       cfg
);

    rgbw_pkg::cfg_t cfg_reg;
    rgbw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rgbw_pkg::REG_CONVERT_MODE:
                    cfg_next.convert_mode = rgbw_pkg::convert_mode_t'(cfg_data[1:0]);
                rgbw_pkg::REG_RED_GAIN:   cfg_next.red_gain   = cfg_data;
                rgbw_pkg::REG_GREEN_GAIN: cfg_next.green_gain = cfg_data;
                rgbw_pkg::REG_BLUE_GAIN:  cfg_next.blue_gain  = cfg_data;
                rgbw_pkg::REG_WHITE_SLOT: cfg_next.white_slot = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.convert_mode <= rgbw_pkg::MODE_EXACT;
            cfg_reg.red_gain     <= 8'd255;
            cfg_reg.green_gain   <= 8'd255;
            cfg_reg.blue_gain    <= 8'd255;
            cfg_reg.white_slot   <= 2'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/rgbw_datapath.sv
// gain scaling, white extraction and slot packing for one pixel
// depends on rgbw_pkg
`default_nettype none

module rgbw_datapath (
    input  wire rgbw_pkg::cfg_t   cfg,
    input  wire rgbw_pkg::pixel_t pixel,
    output rgbw_pkg::rgbw_t       rgbw
);

    localparam logic [7:0] BOOST_LIMIT = 8'd84;
    localparam logic [7:0] WHITE_FULL  = 8'd255;

    function automatic logic [7:0] scale(input logic [7:0] v, input logic [7:0] gain);
        logic [15:0] prod;
        begin
            // 255 * 256 still fits in 16 bits
            prod  = {8'd0, v} * ({8'd0, gain} + 16'd1);
            scale = prod[15:8];
        end
    endfunction

    function automatic logic [7:0] least3(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        logic [7:0] m;
        begin
            m      = (a < b) ? a : b;
            least3 = (m < c) ? m : c;
        end
    endfunction

    logic [7:0] red_s;
    logic [7:0] green_s;
    logic [7:0] blue_s;
    logic [7:0] min_s;
    logic [7:0] white;
    logic [7:0] sub;
    logic [7:0] red_c;
    logic [7:0] green_c;
    logic [7:0] blue_c;

    always_comb
    begin
        red_s   = scale(pixel.red_in,   cfg.red_gain);
        green_s = scale(pixel.green_in, cfg.green_gain);
        blue_s  = scale(pixel.blue_in,  cfg.blue_gain);
        min_s   = least3(red_s, green_s, blue_s);

        case (cfg.convert_mode)
            rgbw_pkg::MODE_EXACT:
            begin
                white = min_s;
                sub   = min_s;
            end
            rgbw_pkg::MODE_MAX_BRIGHT:
            begin
                white = least3(pixel.red_in, pixel.green_in, pixel.blue_in);
                sub   = 8'd0;
            end
            rgbw_pkg::MODE_NULL_WHITE:
            begin
                white = 8'd0;
                sub   = 8'd0;
            end
            rgbw_pkg::MODE_WHITE_BOOST:
            begin
                if (min_s <= BOOST_LIMIT)
                begin
                    // 3*m stays below 256 here
                    white = {min_s[6:0], 1'b0} + min_s;
                    sub   = min_s;
                end
                else
                begin
                    white = WHITE_FULL;
                    sub   = BOOST_LIMIT;
                end
            end
            default:
            begin
                white = 8'd0;
                sub   = 8'd0;
            end
        endcase

        // sub never exceeds the smallest scaled colour
        red_c   = red_s   - sub;
        green_c = green_s - sub;
        blue_c  = blue_s  - sub;

        case (cfg.white_slot)
            2'd0:    rgbw = '{slot0: white, slot1: red_c, slot2: green_c, slot3: blue_c};
            2'd1:    rgbw = '{slot0: red_c, slot1: white, slot2: green_c, slot3: blue_c};
            2'd2:    rgbw = '{slot0: red_c, slot1: green_c, slot2: white, slot3: blue_c};
            default: rgbw = '{slot0: red_c, slot1: green_c, slot2: blue_c, slot3: white};
        endcase
    end

endmodule

`default_nettype wire

// File: design/rgb_to_rgbw_pixel_converter_core.sv
// Converts one rgb pixel word into four led drive bytes, one word per clock
// sustained while rgbw_stall stays low. A word is captured in the input register,
// goes through the gain multipliers, white extraction and slot packing, and lands
// in the output register, which drives rgbw_valid; while the output register holds
// a stalled word, the move waits. The input register frees up whenever the output
// register is empty or being taken, so a word is accepted every cycle while
// rgbw_stall stays low, and one more word is held while a finished word waits.
// Configuration writes take effect at the next edge and should only be made
// with the pipeline empty.
// depends on rgbw_pkg, rgbw_cfg, rgbw_datapath and the defines header
`default_nettype none
`include "rgb_to_rgbw_pixel_converter_core_defines.svh"

module rgb_to_rgbw_pixel_converter_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire rgbw_pkg::pixel_t                pixel,
    output logic                                 rgbw_valid,
    input  wire logic                            rgbw_stall,
    output rgbw_pkg::rgbw_t                      rgbw,
    input  wire logic                            cfg_we,
    input  wire logic [rgbw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbw_pkg::CFG_DATA_W-1:0] cfg_data
);

    rgbw_pkg::cfg_t   cfg;
    rgbw_pkg::pixel_t pix_reg;
    logic             pix_valid_reg;
    rgbw_pkg::rgbw_t  result;
    rgbw_pkg::rgbw_t  out_reg;
    logic             out_valid_reg;
    logic             out_en;
    logic             in_en;

    rgbw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rgbw_datapath u_datapath (
        .cfg   (cfg),
        .pixel (pix_reg),
        .rgbw  (result)
    );

    // output register loads when empty or when its word is taken
    assign out_en      = !out_valid_reg || !rgbw_stall;
    assign in_en       = !pix_valid_reg || out_en;
    assign pixel_stall = !in_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                pix_valid_reg <= pixel_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= pix_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && pixel_valid)
        begin
            pix_reg <= pixel;
        end
        if (out_en && pix_valid_reg)
        begin
            out_reg <= result;
        end
    end

    assign rgbw_valid = out_valid_reg;
    assign rgbw       = out_reg;

    // back-pressure only while a word is held
    `RGBW_ASSERT_NOW(a_stall_needs_word, clk, rst_n, pixel_stall, pix_valid_reg && out_valid_reg)
    // a held word moves to the output when the output frees up
    `RGBW_ASSERT_NEXT(a_word_advances, clk, rst_n, pix_valid_reg && out_en, out_valid_reg)
    // a white slot write lands in the config register
    `RGBW_ASSERT_NEXT(a_slot_write, clk, rst_n,
        cfg_we && (cfg_index == rgbw_pkg::REG_WHITE_SLOT),
        cfg.white_slot == $past(cfg_data[1:0]))

endmodule

`default_nettype wire
